FILE: rtl/core/bloom_filter_builder_defines.svh
// assertion macros shared by the bloom filter builder rtl
`ifndef BLOOM_FILTER_BUILDER_DEFINES_SVH
`define BLOOM_FILTER_BUILDER_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define BFB_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequent that must hold in the same cycle as the antecedent
`define BFB_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/bfb_pkg.sv
// shared types and constants of the bloom filter builder
`timescale 1ns / 1ps

package bfb_pkg;

    // field widths
    localparam int KIND_W  = 2;
    localparam int ENTRY_W = 13;
    localparam int HASH_W  = 32;
    localparam int IDX_W   = 9;
    localparam int BYTE_W  = 8;
    localparam int FB_W    = 10;
    localparam int BPK_W   = 6;

    localparam logic [BPK_W-1:0] BPK_RESET = 6'd10;

    // sizing
    localparam int BITS_W          = ENTRY_W + BPK_W;
    localparam int MIN_FILTER_BITS = 64;

    // double hashing
    localparam int DELTA_ROT = 17;
    localparam int BIT_SEL_W = 3;
    localparam int DVD_W     = HASH_W - BIT_SEL_W;

    // slave tdata layout
    localparam int TD_ENTRY_LSB = 0;
    localparam int TD_HASH_LSB  = TD_ENTRY_LSB + ENTRY_W;
    localparam int TD_IDX_LSB   = TD_HASH_LSB + HASH_W;
    localparam int S_TDATA_W    = 56;

    // master tdata layout
    localparam int M_TDATA_W = 24;

    typedef enum logic [KIND_W-1:0] {
        KIND_BEGIN = 2'd0,
        KIND_ADD   = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NOP   = 2'd3
    } t_kind;

endpackage

FILE: rtl/core/bfb_mod.sv
// bit-serial remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps

module bfb_mod #(
    parameter int DVD_W = 29,
    parameter int DVS_W = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVS_W-1:0] o_rem
);

    localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic [DVS_W-1:0] n_rem;

    // restoring step: shift in next dividend bit, subtract when it fits
    always_comb begin
        trial = {r_rem, r_dvd[DVD_W-1]};
        diff  = trial - {1'b0, r_dvs};
        if (trial >= {1'b0, r_dvs}) begin
            n_rem = diff[DVS_W-1:0];
        end else begin
            n_rem = trial[DVS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_cnt <= CNT_W'(DVD_W - 1);
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= n_rem;
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/core/bfb_store.sv
// filter byte store, one write and one registered read port
`timescale 1ns / 1ps

module bfb_store #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/bloom_filter_builder.sv
// bloom filter builder top level: control sequencer, sizing and stream ports
`timescale 1ns / 1ps

// Builds one Bloom filter bit array in an on-chip byte store by double hashing.
// Every slave beat gives exactly one master beat. A begin beat sizes the filter
// as entry_count times the per-key bit count, at least 64 bits, rounded up to
// whole bytes and clamped to MAX_FILTER_BYTES (error set when clamped), then
// sweeps zeros over the new filter bytes, one byte a cycle. An add beat sets
// PROBE_COUNT bits: bit h mod size, then h += delta, where delta is the beat's
// hash rotated right by 17, wrapping at 32 bits. Each probe runs the
// bit-serial remainder unit (the hash over eight divided by the byte count)
// and a read-modify-write of one store byte. A read beat returns one filter
// byte, or error with a zero byte when the index lies beyond the filter.
// Before the first begin the filter is empty: adds set nothing and every read
// reports error. The store needs no clearing after reset since only bytes
// inside a swept filter are ever read. The user must write the per-key bit
// count on the configuration channel only while the block is idle; the block
// itself does not enforce this. The result register lets a new beat in while
// the last result still waits on the master side.
module bloom_filter_builder #(
    parameter int MAX_FILTER_BYTES = 512,
    parameter int PROBE_COUNT      = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bfb_pkg::BPK_W-1:0]      i_cfg_data,     // per-key bit count
    // slave side
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // entry_count[12:0], key_hash[44:13], byte_index[53:45], zero pad
    input  logic [bfb_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic [bfb_pkg::KIND_W-1:0]     i_s_axis_tuser, // kind[1:0]
    // master side
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // byte_value[7:0], filter_bytes[17:8], error[18], zero pad
    output logic [bfb_pkg::M_TDATA_W-1:0]  o_m_axis_tdata
);

`include "bloom_filter_builder_defines.svh"

    localparam int AW = (MAX_FILTER_BYTES > 1) ? $clog2(MAX_FILTER_BYTES) : 1;
    localparam int BW = $clog2(MAX_FILTER_BYTES + 1);
    localparam int CW = (BW > bfb_pkg::IDX_W) ? BW : bfb_pkg::IDX_W;
    localparam int PW = $clog2(PROBE_COUNT + 1);
    localparam int BYTES_W = bfb_pkg::BITS_W - 2;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CLEAR  = 6'b000010,
        S_DIV    = 6'b000100,
        S_SET    = 6'b001000,
        S_RDWAIT = 6'b010000,
        S_RESULT = 6'b100000
    } t_state;

    t_state                          r_state, n_state;
    logic [bfb_pkg::BPK_W-1:0]       r_bpk;
    logic [BW-1:0]                   r_filter_bytes, n_filter_bytes;
    logic [BW-1:0]                   r_sweep, n_sweep;
    logic [bfb_pkg::HASH_W-1:0]      r_h, n_h;
    logic [bfb_pkg::HASH_W-1:0]      r_delta, n_delta;
    logic [PW-1:0]                   r_probe, n_probe;
    logic [AW-1:0]                   r_addr, n_addr;
    logic [bfb_pkg::BIT_SEL_W-1:0]   r_bit, n_bit;
    logic [bfb_pkg::BYTE_W-1:0]      r_res_byte, n_res_byte;
    logic                            r_res_err, n_res_err;
    logic                            r_m_valid, n_m_valid;
    logic [bfb_pkg::M_TDATA_W-1:0]   r_m_data, n_m_data;

    // unpacked slave beat
    bfb_pkg::t_kind                  in_kind;
    logic [bfb_pkg::ENTRY_W-1:0]     in_entries;
    logic [bfb_pkg::HASH_W-1:0]      in_hash;
    logic [bfb_pkg::IDX_W-1:0]       in_idx;
    logic                            s_accept;

    // sizing of a new filter
    logic [bfb_pkg::BITS_W-1:0]      size_bits;
    logic [bfb_pkg::BITS_W-1:0]      size_min_bits;
    logic [bfb_pkg::BITS_W:0]        size_round;
    logic [BYTES_W-1:0]              size_bytes;
    logic                            size_clamped;
    logic [BW-1:0]                   size_new;

    // read index check
    logic [CW-1:0]                   idx_ext;
    logic                            idx_ok;

    logic [bfb_pkg::HASH_W-1:0]      in_delta;
    logic [BW+bfb_pkg::FB_W-1:0]     fb_ext;
    logic                            out_load;

    // store and remainder unit hookup
    logic                            mem_we;
    logic [AW-1:0]                   mem_waddr;
    logic [bfb_pkg::BYTE_W-1:0]      mem_wdata;
    logic                            mem_re;
    logic [AW-1:0]                   mem_raddr;
    logic [bfb_pkg::BYTE_W-1:0]      mem_rdata;
    logic                            div_start;
    logic [bfb_pkg::DVD_W-1:0]       div_dividend;
    logic                            div_done;
    logic [BW-1:0]                   div_rem;

    assign in_kind    = bfb_pkg::t_kind'(i_s_axis_tuser);
    assign in_entries = i_s_axis_tdata[bfb_pkg::TD_ENTRY_LSB +: bfb_pkg::ENTRY_W];
    assign in_hash    = i_s_axis_tdata[bfb_pkg::TD_HASH_LSB +: bfb_pkg::HASH_W];
    assign in_idx     = i_s_axis_tdata[bfb_pkg::TD_IDX_LSB +: bfb_pkg::IDX_W];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // step between probes: hash rotated right
    assign in_delta = {in_hash[bfb_pkg::DELTA_ROT-1:0],
                       in_hash[bfb_pkg::HASH_W-1:bfb_pkg::DELTA_ROT]};

    // entries times bits per key, floor of 64 bits, whole bytes, capacity clamp
    always_comb begin
        size_bits     = bfb_pkg::BITS_W'(in_entries) * bfb_pkg::BITS_W'(r_bpk);
        size_min_bits = (size_bits < bfb_pkg::BITS_W'(bfb_pkg::MIN_FILTER_BITS)) ?
                        bfb_pkg::BITS_W'(bfb_pkg::MIN_FILTER_BITS) : size_bits;
        size_round    = (bfb_pkg::BITS_W + 1)'(size_min_bits) + (bfb_pkg::BITS_W + 1)'(7);
        size_bytes    = size_round[bfb_pkg::BITS_W:bfb_pkg::BIT_SEL_W];
        size_clamped  = size_bytes > BYTES_W'(MAX_FILTER_BYTES);
        size_new      = size_clamped ? BW'(MAX_FILTER_BYTES) : BW'(size_bytes);
    end

    // a read inside the filter is also inside the store
    assign idx_ext = CW'(in_idx);
    assign idx_ok  = idx_ext < CW'(r_filter_bytes);

    assign out_load = (r_state == S_RESULT) && (!r_m_valid || i_m_axis_tready);
    assign fb_ext   = (BW + bfb_pkg::FB_W)'(r_filter_bytes);

    always_comb begin
        n_state        = r_state;
        n_filter_bytes = r_filter_bytes;
        n_sweep        = r_sweep;
        n_h            = r_h;
        n_delta        = r_delta;
        n_probe        = r_probe;
        n_addr         = r_addr;
        n_bit          = r_bit;
        n_res_byte     = r_res_byte;
        n_res_err      = r_res_err;
        mem_we         = 1'b0;
        mem_waddr      = r_addr;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = idx_ext[AW-1:0];
        div_start      = 1'b0;
        div_dividend   = r_h[bfb_pkg::HASH_W-1:bfb_pkg::BIT_SEL_W];

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_res_byte = '0;
                    n_res_err  = 1'b0;
                    unique case (in_kind)
                        bfb_pkg::KIND_BEGIN: begin
                            n_filter_bytes = size_new;
                            n_res_err      = size_clamped;
                            n_sweep        = '0;
                            n_state        = S_CLEAR;
                        end
                        bfb_pkg::KIND_ADD: begin
                            n_h     = in_hash;
                            n_delta = in_delta;
                            n_probe = '0;
                            if (r_filter_bytes != '0) begin
                                // first probe starts at once from the beat
                                div_start    = 1'b1;
                                div_dividend = in_hash[bfb_pkg::HASH_W-1:bfb_pkg::BIT_SEL_W];
                                n_state      = S_DIV;
                            end else begin
                                n_state = S_RESULT;
                            end
                        end
                        bfb_pkg::KIND_READ: begin
                            if (idx_ok) begin
                                mem_re  = 1'b1;
                                n_state = S_RDWAIT;
                            end else begin
                                n_res_err = 1'b1;
                                n_state   = S_RESULT;
                            end
                        end
                        bfb_pkg::KIND_NOP: begin
                            n_state = S_RESULT;
                        end
                        default: begin
                            n_state = S_RESULT;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                // zero sweep over the new filter bytes only
                mem_we    = 1'b1;
                mem_waddr = r_sweep[AW-1:0];
                n_sweep   = r_sweep + BW'(1);
                if (r_sweep + BW'(1) == r_filter_bytes) begin
                    n_state = S_RESULT;
                end
            end
            S_DIV: begin
                // byte = (h / 8) mod bytes, bit = h mod 8
                mem_raddr = div_rem[AW-1:0];
                if (div_done) begin
                    mem_re  = 1'b1;
                    n_addr  = div_rem[AW-1:0];
                    n_bit   = r_h[bfb_pkg::BIT_SEL_W-1:0];
                    n_h     = r_h + r_delta;
                    n_probe = r_probe + PW'(1);
                    n_state = S_SET;
                end
            end
            S_SET: begin
                // probes are many cycles apart, so no write can be in flight here
                mem_we    = 1'b1;
                mem_wdata = mem_rdata | (bfb_pkg::BYTE_W'(1) << r_bit);
                if (r_probe == PW'(PROBE_COUNT)) begin
                    n_state = S_RESULT;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_RDWAIT: begin
                n_res_byte = mem_rdata;
                n_state    = S_RESULT;
            end
            S_RESULT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // master side result register
    always_comb begin
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        if (out_load) begin
            n_m_valid = 1'b1;
            n_m_data  = bfb_pkg::M_TDATA_W'({r_res_err, fb_ext[bfb_pkg::FB_W-1:0],
                                              r_res_byte});
        end else if (i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_filter_bytes <= '0;
            r_bpk          <= bfb_pkg::BPK_RESET;
            r_m_valid      <= 1'b0;
            r_probe        <= '0;
        end else begin
            r_state        <= n_state;
            r_filter_bytes <= n_filter_bytes;
            r_m_valid      <= n_m_valid;
            r_probe        <= n_probe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_bpk <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sweep    <= n_sweep;
        r_h        <= n_h;
        r_delta    <= n_delta;
        r_addr     <= n_addr;
        r_bit      <= n_bit;
        r_res_byte <= n_res_byte;
        r_res_err  <= n_res_err;
        r_m_data   <= n_m_data;
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    bfb_store #(
        .DEPTH  (MAX_FILTER_BYTES),
        .ADDR_W (AW),
        .DATA_W (bfb_pkg::BYTE_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bfb_mod #(
        .DVD_W (bfb_pkg::DVD_W),
        .DVS_W (BW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_filter_bytes),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    `BFB_ASSERT_HOLDS(a_size_in_store, r_filter_bytes <= BW'(MAX_FILTER_BYTES), "filter larger than store")
    `BFB_ASSERT_IMPLIES(a_done_in_div, div_done, r_state == S_DIV, "remainder done outside probe wait")
    `BFB_ASSERT_IMPLIES(a_set_in_filter, r_state == S_SET, BW'(r_addr) < r_filter_bytes, "probe byte beyond filter")
    `BFB_ASSERT_IMPLIES(a_sweep_in_filter, r_state == S_CLEAR, r_sweep < r_filter_bytes, "clear sweep beyond filter")
    `BFB_ASSERT_HOLDS(a_probe_bound, r_probe <= PW'(PROBE_COUNT), "probe count overrun")

endmodule

FILE: dv/tb.sv
// self-checking testbench for the bloom filter builder: directed table, then random phases
`timescale 1ns / 1ps

module tb;
    import bfb_pkg::*;

    localparam int MAX_BYTES    = 512;
    localparam int PROBES       = 6;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 116;
    // slowest item is a full-size begin plus both random stalls; the limit allows
    // several times a run made only of such items
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int PRINT_CAP    = 40;

    // one master beat, unpacked
    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic [FB_W-1:0]   filter_bytes;
        logic              err;
    } t_reply;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_op;

    typedef struct packed {
        t_row_op             op;
        t_kind               kind;
        logic [ENTRY_W-1:0]  entries;
        logic [HASH_W-1:0]   hash;
        logic [IDX_W-1:0]    idx;
        logic [BPK_W-1:0]    bpk;
        logic                fixed_want;
        t_reply              want;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [BPK_W-1:0]      i_cfg_data;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [S_TDATA_W-1:0]  i_s_axis_tdata;
    logic [KIND_W-1:0]     i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;

    bloom_filter_builder #(
        .MAX_FILTER_BYTES (MAX_BYTES),
        .PROBE_COUNT      (PROBES)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // shadow of the filter state
    logic [BYTE_W-1:0] shadow_store [MAX_BYTES];
    int unsigned       shadow_bits;
    logic [BPK_W-1:0]  shadow_bpk;

    t_reply replies_due [$];
    t_row   directed_rows [$];

    int  mismatches = 0;
    int  replies_seen = 0;
    int  cycle_count = 0;
    int  n_begin;
    int  n_add;
    int  n_read;
    int  n_nop;
    int  n_cfg;
    bit  no_idling;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("%0t ns  mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // applies one accepted beat to the shadow state and returns its reply
    function automatic t_reply filter_reply(input t_kind kind,
                                            input logic [ENTRY_W-1:0] entries,
                                            input logic [HASH_W-1:0] hash,
                                            input logic [IDX_W-1:0] idx);
        t_reply            r;
        int unsigned       bits;
        int unsigned       nbytes;
        int unsigned       pos;
        logic [HASH_W-1:0] h;
        logic [HASH_W-1:0] delta;
        r = '0;
        case (kind)
            KIND_BEGIN: begin
                bits = 32'(entries) * 32'(shadow_bpk);
                if (bits < MIN_FILTER_BITS)
                    bits = MIN_FILTER_BITS;
                nbytes = (bits + 7) / 8;
                if (nbytes > MAX_BYTES) begin
                    nbytes = MAX_BYTES;
                    r.err  = 1'b1;
                end
                shadow_bits = nbytes * 8;
                for (int i = 0; i < MAX_BYTES; i++)
                    shadow_store[i] = '0;
            end
            KIND_ADD: begin
                // no filter yet: nothing to set
                if (shadow_bits != 0) begin
                    h     = hash;
                    delta = {hash[DELTA_ROT-1:0], hash[HASH_W-1:DELTA_ROT]};
                    for (int p = 0; p < PROBES; p++) begin
                        pos = h % shadow_bits;
                        shadow_store[pos / 8][pos % 8] = 1'b1;
                        h = h + delta;
                    end
                end
            end
            KIND_READ: begin
                if (idx < shadow_bits / 8)
                    r.byte_value = shadow_store[idx];
                else
                    r.err = 1'b1;
            end
            default: ;
        endcase
        r.filter_bytes = FB_W'(shadow_bits / 8);
        return r;
    endfunction

    task automatic row_item(input t_kind kind, input int entries, input logic [HASH_W-1:0] hash,
                            input int idx, input bit fixed_want, input int b, input int fb,
                            input bit e);
        t_row row;
        row            = '0;
        row.op         = ROW_ITEM;
        row.kind       = kind;
        row.entries    = ENTRY_W'(entries);
        row.hash       = hash;
        row.idx        = IDX_W'(idx);
        row.fixed_want = fixed_want;
        row.want       = '{byte_value: BYTE_W'(b), filter_bytes: FB_W'(fb), err: e};
        directed_rows.push_back(row);
    endtask

    task automatic row_cfg(input int bpk);
        t_row row;
        row     = '0;
        row.op  = ROW_CFG;
        row.bpk = BPK_W'(bpk);
        directed_rows.push_back(row);
    endtask

    // presents one slave beat, holds it until taken, then records its reply
    task automatic send_item(input t_kind kind, input logic [ENTRY_W-1:0] entries,
                             input logic [HASH_W-1:0] hash, input logic [IDX_W-1:0] idx,
                             input bit fixed_want, input t_reply want);
        t_reply pred;
        if (!no_idling && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= {{(S_TDATA_W - IDX_W - HASH_W - ENTRY_W){1'b0}}, idx, hash, entries};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pred = filter_reply(kind, entries, hash, idx);
        replies_due.push_back(fixed_want ? want : pred);
        case (kind)
            KIND_BEGIN: n_begin++;
            KIND_ADD:   n_add++;
            KIND_READ:  n_read++;
            default:    n_nop++;
        endcase
    endtask

    // register writes only once every reply is back and nothing is offered
    task automatic write_key_bits(input logic [BPK_W-1:0] value);
        i_s_axis_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        shadow_bpk = value;
        n_cfg++;
    endtask

    // master side: compare each beat, and stall tready in bursts
    always @(posedge i_clk) begin : take_replies
        t_reply got;
        t_reply want;
        int     stall_left;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.byte_value   = o_m_axis_tdata[7:0];
            got.filter_bytes = o_m_axis_tdata[17:8];
            got.err          = o_m_axis_tdata[18];
            replies_seen++;
            if (replies_due.size() == 0) begin
                flag_mismatch($sformatf("result beat with nothing expected (tdata %h)",
                                        o_m_axis_tdata));
            end else begin
                want = replies_due.pop_front();
                if (got.byte_value != want.byte_value)
                    flag_mismatch($sformatf("beat %0d byte_value %h, want %h",
                                            replies_seen, got.byte_value, want.byte_value));
                if (got.filter_bytes != want.filter_bytes)
                    flag_mismatch($sformatf("beat %0d filter_bytes %0d, want %0d",
                                            replies_seen, got.filter_bytes, want.filter_bytes));
                if (got.err != want.err)
                    flag_mismatch($sformatf("beat %0d error %b, want %b",
                                            replies_seen, got.err, want.err));
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (!no_idling && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycle_count, replies_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        t_kind              kind;
        logic [ENTRY_W-1:0] entries;
        logic [HASH_W-1:0]  hash;
        logic [IDX_W-1:0]   idx;
        logic [BPK_W-1:0]   bpk;
        int unsigned        pick;
        int unsigned        cur_bytes;

        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = KIND_NOP;
        n_begin         = 0;
        n_add           = 0;
        n_read          = 0;
        n_nop           = 0;
        n_cfg           = 0;
        no_idling       = 1'b0;
        shadow_bits     = 0;
        shadow_bpk      = BPK_RESET;
        for (int i = 0; i < MAX_BYTES; i++)
            shadow_store[i] = '0;

        // before any begin: adds set nothing, reads report error
        row_item(KIND_READ,  0,    32'h0,         0,   1, 0, 0,   1);
        row_item(KIND_ADD,   0,    32'hFFFF_FFFF, 0,   1, 0, 0,   0);
        row_item(KIND_NOP,   8191, 32'hFFFF_FFFF, 511, 1, 0, 0,   0);
        row_item(KIND_READ,  0,    32'h0,         511, 1, 0, 0,   1);
        // zero entries gives the 64-bit minimum
        row_item(KIND_BEGIN, 0,    32'h0,         0,   1, 0, 8,   0);
        row_item(KIND_ADD,   0,    32'h0,         0,   0, 0, 0,   0);
        row_item(KIND_ADD,   0,    32'hFFFF_FFFF, 0,   0, 0, 0,   0);
        row_item(KIND_READ,  0,    32'h0,         0,   0, 0, 0,   0);
        row_item(KIND_READ,  0,    32'h0,         7,   0, 0, 0,   0);
        row_item(KIND_READ,  0,    32'h0,         8,   1, 0, 8,   1);
        row_item(KIND_NOP,   0,    32'h0,         0,   1, 0, 8,   0);
        // largest count is clamped to the store
        row_item(KIND_BEGIN, 8191, 32'h0,         0,   1, 0, 512, 1);
        row_item(KIND_ADD,   0,    32'h8000_0000, 0,   0, 0, 0,   0);
        row_item(KIND_ADD,   0,    32'h1234_5678, 0,   0, 0, 0,   0);
        row_item(KIND_READ,  0,    32'h0,         511, 0, 0, 0,   0);
        row_item(KIND_READ,  0,    32'h0,         0,   0, 0, 0,   0);
        row_cfg(63);
        row_item(KIND_BEGIN, 8191, 32'h0,         0,   1, 0, 512, 1);
        // 4095 bits rounds up to exactly the store size, one more entry overflows
        row_item(KIND_BEGIN, 65,   32'h0,         0,   1, 0, 512, 0);
        row_item(KIND_BEGIN, 66,   32'h0,         0,   1, 0, 512, 1);
        row_cfg(0);
        row_item(KIND_BEGIN, 8191, 32'h0,         0,   1, 0, 8,   0);
        row_item(KIND_ADD,   0,    32'hAAAA_AAAA, 0,   0, 0, 0,   0);
        row_item(KIND_READ,  0,    32'h0,         3,   0, 0, 0,   0);
        row_cfg(1);
        // 71 bits rounds up to nine bytes
        row_item(KIND_BEGIN, 71,   32'h0,         0,   1, 0, 9,   0);
        row_item(KIND_ADD,   0,    32'h5555_5555, 0,   0, 0, 0,   0);
        row_item(KIND_READ,  0,    32'h0,         8,   0, 0, 0,   0);
        row_item(KIND_READ,  0,    32'h0,         9,   1, 0, 9,   1);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].op == ROW_CFG)
                write_key_bits(directed_rows[i].bpk);
            else
                send_item(directed_rows[i].kind, directed_rows[i].entries,
                          directed_rows[i].hash, directed_rows[i].idx,
                          directed_rows[i].fixed_want, directed_rows[i].want);
        end

        // random phases, each at its own per-key bit count; the last runs without idling
        for (int ph = 0; ph < PHASES; ph++) begin
            no_idling = (ph == PHASES - 1);
            case (ph)
                0:       bpk = 6'd1;
                1:       bpk = 6'd63;
                2:       bpk = 6'd0;
                3:       bpk = 6'd32;
                6:       bpk = BPK_RESET;
                default: bpk = BPK_W'($urandom_range(0, 63));
            endcase
            write_key_bits(bpk);
            // a well-formed phase opens with a begin of modest size
            send_item(KIND_BEGIN, ENTRY_W'($urandom_range(0, 64)), $urandom,
                      IDX_W'($urandom), 1'b0, '0);
            repeat (PHASE_ITEMS) begin
                // unused fields carry random noise
                entries   = ENTRY_W'($urandom);
                hash      = $urandom;
                idx       = IDX_W'($urandom);
                cur_bytes = shadow_bits / 8;
                pick      = $urandom_range(0, 99);
                if (pick < 6) begin
                    kind = KIND_BEGIN;
                    if ($urandom_range(0, 9) != 0)
                        entries = ENTRY_W'($urandom_range(0, 64));
                end else if (pick < 56) begin
                    kind = KIND_ADD;
                end else if (pick < 94) begin
                    kind = KIND_READ;
                    // mostly inside the filter, sometimes anywhere in the index range
                    if (cur_bytes != 0 && $urandom_range(0, 4) != 0)
                        idx = IDX_W'($urandom_range(0, cur_bytes - 1));
                end else begin
                    kind = KIND_NOP;
                end
                send_item(kind, entries, hash, idx, 1'b0, '0);
            end
        end

        i_s_axis_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        // catch any stray beat after the last one
        repeat (50) @(posedge i_clk);

        $display("stimulus: %0d begins, %0d adds, %0d reads, %0d no-ops, %0d register writes",
                 n_begin, n_add, n_read, n_nop, n_cfg);
        $display("%0d result beats compared, %0d mismatches", replies_seen, mismatches);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/bfb_pkg.sv
rtl/core/bfb_mod.sv
rtl/core/bfb_store.sv
rtl/core/bloom_filter_builder.sv
dv/tb.sv
